// ===== rtl/trsmb_pkg.sv =====
package trsmb_pkg;

    // Working widths of the angle path (Q2.30 with head room) and the CORDIC x/y path.
    localparam int ZW = 36;
    localparam int XW = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int Q30_SHIFT = 30;

    localparam logic signed [ZW-1:0] Q30_PI       = 36'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI  = 36'sd1686629713;
    localparam logic signed [ZW-1:0] Q30_TWO_PI   = 36'sd6746518852;
    localparam logic [63:0]          Q30_TWO_PI_U = 64'd6746518852;
    localparam logic signed [XW-1:0] CORDIC_GAIN  = 34'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_TAB [10] = '{
        36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159, 36'sd67021687,
        36'sd33543516,  36'sd16775851,  36'sd8388437,   36'sd4194283,   36'sd2097149
    };

    // Index of the final element of a matrix on the result port.
    localparam logic [3:0] LAST_IDX = 4'd11;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } side_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
        logic signed [ZW-1:0] v;
        if (i < 10) begin
            v = ATAN_TAB[i];
        end else begin
            v = 36'sd1 <<< (30 - i);
        end
        return v;
    endfunction

endpackage

// ===== rtl/trsmb_cordic.sv =====
module trsmb_cordic import trsmb_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 12
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [15:0]   angle,
    output logic signed [XW-1:0] cos_q,
    output logic signed [XW-1:0] sin_q
);

    localparam int SH = Q30_SHIFT - ANGLE_FRAC_BITS;
    localparam logic [63:0] TWO_PI_A = (Q30_TWO_PI_U + (64'd1 << (SH - 1))) >> SH;
    localparam int QB = $clog2(64'd32768 / TWO_PI_A + 64'd1);

    logic signed [17:0]   wrap_reg;
    logic signed [17:0]   wrap_next;
    logic signed [ZW-1:0] fold_reg;
    logic signed [ZW-1:0] fold_next;
    logic signed [ZW-1:0] z_reg [0:CORDIC_STEPS];
    logic signed [XW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [XW-1:0] y_reg [0:CORDIC_STEPS];
    logic                 neg_reg [0:CORDIC_STEPS];
    logic signed [XW-1:0] cos_reg;
    logic signed [XW-1:0] sin_reg;

    // Wrap toward zero by 2*pi, keeping the sign: a short restoring remainder.
    always_comb begin
        logic signed [16:0] ax;
        logic [16:0]        rem;
        logic signed [17:0] w;
        ax  = 17'(angle);
        rem = ax[16] ? 17'(-ax) : 17'(ax);
        for (int k = QB - 1; k >= 0; k--) begin
            if ({47'd0, rem} >= (TWO_PI_A << k)) begin
                rem = rem - 17'(TWO_PI_A << k);
            end
        end
        w         = {1'b0, rem};
        wrap_next = angle[15] ? -w : w;
    end

    always_comb begin
        logic signed [ZW-1:0] z;
        z = ZW'(wrap_reg) <<< SH;
        if (z > Q30_PI) begin
            z = z - Q30_TWO_PI;
        end else if (z < -Q30_PI) begin
            z = z + Q30_TWO_PI;
        end
        fold_next = z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wrap_reg <= wrap_next;
            fold_reg <= fold_next;
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            if (fold_reg > Q30_HALF_PI) begin
                z_reg[0]   <= fold_reg - Q30_PI;
                neg_reg[0] <= 1'b1;
            end else if (fold_reg < -Q30_HALF_PI) begin
                z_reg[0]   <= fold_reg + Q30_PI;
                neg_reg[0] <= 1'b1;
            end else begin
                z_reg[0]   <= fold_reg;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1] <= neg_reg[i];
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= neg_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
            sin_reg <= neg_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

// ===== rtl/trs_model_matrix_builder_top.sv =====
// Builds the model matrix T*Rx*Ry*Rz*S from a Q16.16 position, three Q4.12 Euler angles
// and a Q16.16 scale per axis, and sends the top three rows as twelve items in row-major
// order, the twelfth marked by m_last; the bottom row is always 0,0,0,1 and is not sent.
// Every angle is wrapped by 2*pi keeping its sign, then sine and cosine come from three
// 30-step CORDIC pipelines, one per axis. The input side is a 41-stage pipeline that can
// take a new item in every cycle while it has room. The single-element result port sends
// all twelve items of one transform before it takes the next finished matrix; when the
// final stage holds a matrix that the result port cannot yet take, the whole pipeline
// holds and nothing is lost. Rotation elements saturate to the 32-bit range;
// the translation column is passed through unchanged.
module trs_model_matrix_builder_top import trsmb_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [15:0] s_angle_x,
    input  logic signed [15:0] s_angle_y,
    input  logic signed [15:0] s_angle_z,
    input  logic signed [31:0] s_scale_x,
    input  logic signed [31:0] s_scale_y,
    input  logic signed [31:0] s_scale_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_row,
    output logic [1:0]         m_column,
    output logic signed [31:0] m_element,
    output logic               m_last
);

    // Stage numbering: 0..33 inside the CORDIC lanes, 34..40 for the matrix arithmetic.
    localparam int LANE_LAST = CORDIC_STEPS + 3;
    localparam int DEPTH     = LANE_LAST + 8;
    localparam int PW        = 2 * XW;

    logic        v_reg [0:DEPTH-1];
    side_t       side_reg [0:DEPTH-1];
    logic        adv;
    logic        ser_take;
    logic        ser_load;

    logic signed [XW-1:0] cx, sx, cy, sy, cz, sz;

    // First products: cy*cz, cy*sz, cx*sz, sx*sy, cx*cz, sx*cy, sx*sz, cx*sy, sx*cz, cx*cy.
    logic signed [PW-1:0] p1_reg [10];
    logic signed [ZW-1:0] q1_reg [10];
    logic signed [ZW-1:0] q1d_reg [10];
    logic signed [ZW-1:0] r_reg [9];
    logic signed [ZW+31:0] e_reg [9];
    logic signed [31:0]   el_reg [12];
    logic signed [31:0]   out_reg [12];
    logic                 busy_reg;
    logic [3:0]           cnt_reg;

    function automatic logic signed [ZW-1:0] rnd30(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + (PW'(1) <<< (Q30_SHIFT - 1));
        return t[Q30_SHIFT +: ZW];
    endfunction

    function automatic logic signed [31:0] rnd_sat(input logic signed [ZW+31:0] p);
        logic signed [ZW+31:0] t;
        logic signed [ZW+1:0]  v;
        logic signed [31:0]    o;
        t = p + ((ZW+32)'(1) <<< (Q30_SHIFT - 1));
        v = t[ZW+31:Q30_SHIFT];
        if (v > (ZW+2)'(32'sh7fffffff)) begin
            o = 32'sh7fffffff;
        end else if (v < -(ZW+2)'(33'sh080000000)) begin
            o = 32'sh80000000;
        end else begin
            o = v[31:0];
        end
        return o;
    endfunction

    assign ser_take = !busy_reg || (cnt_reg == LAST_IDX && m_ready);
    assign adv      = !v_reg[DEPTH-1] || ser_take;
    assign s_ready  = adv && aresetn;
    assign ser_load = adv && v_reg[DEPTH-1];

    trsmb_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_x (
        .aclk(aclk), .en(adv), .angle(s_angle_x), .cos_q(cx), .sin_q(sx)
    );
    trsmb_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_y (
        .aclk(aclk), .en(adv), .angle(s_angle_y), .cos_q(cy), .sin_q(sy)
    );
    trsmb_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_z (
        .aclk(aclk), .en(adv), .angle(s_angle_z), .cos_q(cz), .sin_q(sz)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= s_valid;
            for (int k = 1; k < DEPTH; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= '{s_pos_x, s_pos_y, s_pos_z, s_scale_x, s_scale_y, s_scale_z};
            for (int k = 1; k < DEPTH; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Matrix arithmetic, one multiply or one rounding/add per stage.
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg[0] <= cy * cz;
            p1_reg[1] <= cy * sz;
            p1_reg[2] <= cx * sz;
            p1_reg[3] <= sx * sy;
            p1_reg[4] <= cx * cz;
            p1_reg[5] <= sx * cy;
            p1_reg[6] <= sx * sz;
            p1_reg[7] <= cx * sy;
            p1_reg[8] <= sx * cz;
            p1_reg[9] <= cx * cy;
            for (int k = 0; k < 10; k++) begin
                q1_reg[k]  <= rnd30(p1_reg[k]);
                q1d_reg[k] <= q1_reg[k];
            end
        end
    end

    // The second products need cz and sz of the same item: the lane outputs have moved on,
    // so cz and sz are carried alongside the first products.
    logic signed [XW-1:0] cz_reg, sz_reg, cz2_reg, sz2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            cz_reg  <= cz;
            sz_reg  <= sz;
            cz2_reg <= cz_reg;
            sz2_reg <= sz_reg;
        end
    end

    logic signed [PW-1:0] p2b_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2b_reg[0] <= XW'(q1_reg[3]) * cz2_reg;
            p2b_reg[1] <= XW'(q1_reg[3]) * sz2_reg;
            p2b_reg[2] <= XW'(q1_reg[7]) * cz2_reg;
            p2b_reg[3] <= XW'(q1_reg[7]) * sz2_reg;
        end
    end

    logic signed [ZW-1:0] q2b_reg [4];
    logic signed [ZW-1:0] q1e_reg [10];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                q2b_reg[k] <= rnd30(p2b_reg[k]);
            end
            for (int k = 0; k < 10; k++) begin
                q1e_reg[k] <= q1d_reg[k];
            end
        end
    end

    // Stage 38: rotation matrix; sy is carried from the products stage.
    logic signed [XW-1:0] sy_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sy_reg[0] <= sy;
            for (int k = 1; k < 4; k++) begin
                sy_reg[k] <= sy_reg[k-1];
            end
            r_reg[0] <= q1e_reg[0];
            r_reg[1] <= -q1e_reg[1];
            r_reg[2] <= ZW'(sy_reg[3]);
            r_reg[3] <= q1e_reg[2] + q2b_reg[0];
            r_reg[4] <= q1e_reg[4] - q2b_reg[1];
            r_reg[5] <= -q1e_reg[5];
            r_reg[6] <= q1e_reg[6] - q2b_reg[2];
            r_reg[7] <= q1e_reg[8] + q2b_reg[3];
            r_reg[8] <= q1e_reg[9];
        end
    end

    // Stages 39 and 40: scale per column, then round and saturate.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                e_reg[r*3+0] <= r_reg[r*3+0] * side_reg[DEPTH-3].scale_x;
                e_reg[r*3+1] <= r_reg[r*3+1] * side_reg[DEPTH-3].scale_y;
                e_reg[r*3+2] <= r_reg[r*3+2] * side_reg[DEPTH-3].scale_z;
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    el_reg[r*4+c] <= rnd_sat(e_reg[r*3+c]);
                end
            end
            el_reg[3]  <= side_reg[DEPTH-2].pos_x;
            el_reg[7]  <= side_reg[DEPTH-2].pos_y;
            el_reg[11] <= side_reg[DEPTH-2].pos_z;
        end
    end

    // Output serialiser: holds one finished matrix and sends it one item at a time.
    always_ff @(posedge aclk) begin
        if (ser_load) begin
            for (int k = 0; k < 12; k++) begin
                out_reg[k] <= el_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (ser_load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            if (cnt_reg == LAST_IDX) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    assign m_valid   = busy_reg;
    assign m_row     = cnt_reg[3:2];
    assign m_column  = cnt_reg[1:0];
    assign m_element = out_reg[cnt_reg];
    assign m_last    = (cnt_reg == LAST_IDX);

`ifndef ASSERT_OFF
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_row == 2'd2 && m_column == 2'd3)
        else $error("last item is not the final element");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv && v_reg[DEPTH-1] |=> v_reg[DEPTH-1])
        else $error("stalled matrix dropped from the pipeline");
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && m_last && m_ready && !v_reg[DEPTH-1] |=> !busy_reg)
        else $error("serialiser kept running after the last item");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[DEPTH-1] |-> s_ready)
        else $error("input refused with an empty final stage");
`endif

endmodule

// ===== verif/trs_model_matrix_builder_top_tb.sv =====
`timescale 1ns / 1ps

// Checks the model-matrix builder against its own predictor of T*Rx*Ry*Rz*S.
// Every accepted transform produces twelve expected matrix elements, which are
// compared field by field with the result items as they are accepted.
class matrix_scoreboard;
    typedef struct {
        logic [1:0]         row;
        logic [1:0]         column;
        logic signed [31:0] element;
        logic               last;
    } elem_t;

    elem_t pending_elems[$];
    int    error_count;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint GAIN_Q30    = 64'sd652032874;

    function new();
        error_count = 0;
    endfunction

    static function longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    static function longint arctan_q30(int i);
        longint tab[10];
        tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) begin
            return tab[i];
        end
        return longint'(1) << (30 - i);
    endfunction

    static function void sin_cos(logic signed [15:0] ang, output longint c,
                                 output longint s);
        longint a, mag, period, z, x, y, dx, dy;
        bit flip;
        a = ang;
        period = round_shift(TWO_PI_Q30, 18);
        mag = (a < 0) ? -a : a;
        mag = mag % period;
        a = (a < 0) ? -mag : mag;
        z = a <<< 18;
        flip = 0;
        if (z > PI_Q30) z -= TWO_PI_Q30;
        if (z < -PI_Q30) z += TWO_PI_Q30;
        if (z > HALF_PI_Q30) begin
            z -= PI_Q30;
            flip = 1;
        end else if (z < -HALF_PI_Q30) begin
            z += PI_Q30;
            flip = 1;
        end
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_q30(i);
            end else begin
                x += dx; y -= dy; z += arctan_q30(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    static function longint mul_q30(longint a, longint b);
        return round_shift(a * b, 30);
    endfunction

    // Works out the twelve elements of one transform and queues them.
    function void note_transform(logic signed [31:0] pos[3], logic signed [15:0] ang[3],
                                 logic signed [31:0] scl[3]);
        longint cx, sx, cy, sy, cz, sz, v;
        longint rot[3][3];
        elem_t e;
        int k;
        sin_cos(ang[0], cx, sx);
        sin_cos(ang[1], cy, sy);
        sin_cos(ang[2], cz, sz);
        rot[0][0] = mul_q30(cy, cz);
        rot[0][1] = -mul_q30(cy, sz);
        rot[0][2] = sy;
        rot[1][0] = mul_q30(cx, sz) + mul_q30(mul_q30(sx, sy), cz);
        rot[1][1] = mul_q30(cx, cz) - mul_q30(mul_q30(sx, sy), sz);
        rot[1][2] = -mul_q30(sx, cy);
        rot[2][0] = mul_q30(sx, sz) - mul_q30(mul_q30(cx, sy), cz);
        rot[2][1] = mul_q30(sx, cz) + mul_q30(mul_q30(cx, sy), sz);
        rot[2][2] = mul_q30(cx, cy);
        k = 0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (c == 3) begin
                    v = pos[r];
                end else begin
                    v = round_shift(rot[r][c] * longint'(scl[c]), 30);
                    if (v > 64'sd2147483647) v = 64'sd2147483647;
                    if (v < -64'sd2147483648) v = -64'sd2147483648;
                end
                e.row = r[1:0];
                e.column = c[1:0];
                e.element = v[31:0];
                e.last = (k == 11);
                pending_elems.push_back(e);
                k++;
            end
        end
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    task check_element(logic [1:0] row, logic [1:0] column,
                       logic signed [31:0] element, logic last);
        elem_t e;
        if (pending_elems.size() == 0) begin
            report("result item with nothing expected");
            return;
        end
        e = pending_elems.pop_front();
        if (row !== e.row || column !== e.column || element !== e.element
            || last !== e.last) begin
            report($sformatf("got r%0d c%0d %0d l%0d, want r%0d c%0d %0d l%0d",
                             row, column, element, last,
                             e.row, e.column, e.element, e.last));
        end
    endtask
endclass

module trs_model_matrix_builder_top_tb;
    import trsmb_pkg::*;

    // Cycles from acceptance to the first result item, with some margin.
    localparam int PIPE_LATENCY = 60;
    localparam int CYCLE_LIMIT  = 400000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [15:0] s_angle_x = '0, s_angle_y = '0, s_angle_z = '0;
    logic signed [31:0] s_scale_x = '0, s_scale_y = '0, s_scale_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_row, m_column;
    logic signed [31:0] m_element;
    logic               m_last;

    matrix_scoreboard board = new();

    // Idle rates in percent for the sender and the receiver.
    int sender_idle = 27;
    int receiver_idle = 52;
    int cycle_count = 0;

    always #6 aclk = ~aclk;

    trs_model_matrix_builder_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_angle_x(s_angle_x), .s_angle_y(s_angle_y), .s_angle_z(s_angle_z),
        .s_scale_x(s_scale_x), .s_scale_y(s_scale_y), .s_scale_z(s_scale_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_row(m_row), .m_column(m_column), .m_element(m_element), .m_last(m_last)
    );

    // The receiver: ready is redrawn each cycle, and each accepted item is
    // checked against the oldest expected element.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                board.check_element(m_row, m_column, m_element, m_last);
            end
            m_ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    // The watchdog stops a hung run.
    always @(posedge aclk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("trs_model_matrix_builder_top_tb NOT OK");
            $finish;
        end
    end

    // Presents one transform, with a random gap first, and holds it until the
    // block takes it. The expectation is queued at the accepting edge; valid
    // stays high afterwards unless a gap or a drain follows.
    task automatic send_transform(logic signed [31:0] pos[3], logic signed [15:0] ang[3],
                                  logic signed [31:0] scl[3]);
        while ($urandom_range(99) < sender_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_pos_x   <= pos[0];  s_pos_y   <= pos[1];  s_pos_z   <= pos[2];
        s_angle_x <= ang[0];  s_angle_y <= ang[1];  s_angle_z <= ang[2];
        s_scale_x <= scl[0];  s_scale_y <= scl[1];  s_scale_z <= scl[2];
        do begin
            @(posedge aclk);
        end while (!s_ready);
        board.note_transform(pos, ang, scl);
    endtask

    // Mostly modest magnitudes so the products do not all saturate, with a
    // share of full-range values so every bit toggles.
    function automatic logic signed [31:0] pick_q16();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
            default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_angle();
        if ($urandom_range(3) == 0) begin
            return 16'($urandom());
        end
        return $signed(16'($urandom_range(51472))) - 16'sd25736;
    endfunction

    task automatic send_random(int count);
        logic signed [31:0] pos[3], scl[3];
        logic signed [15:0] ang[3];
        repeat (count) begin
            for (int k = 0; k < 3; k++) begin
                pos[k] = $urandom();
                ang[k] = pick_angle();
                scl[k] = pick_q16();
            end
            send_transform(pos, ang, scl);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending_elems.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    logic signed [31:0] dpos[3], dscl[3];
    logic signed [15:0] dang[3];
    logic signed [15:0] edge_angles[12];

    initial begin
        // Wrap and quadrant cases: zero, +-pi/2, +-pi, exactly 2*pi, the extremes.
        edge_angles = '{16'sd0, 16'sd6434, -16'sd6434, 16'sd12868, -16'sd12868,
                        16'sd25736, -16'sd25736, 16'sd25737, 16'sh7fff, -16'sh8000,
                        16'sd1, -16'sd1};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: angle extremes and saturating scales.
        for (int i = 0; i < 12; i++) begin
            dpos = '{32'sh7fffffff, -32'sh80000000, i};
            dang = '{edge_angles[i], edge_angles[(i + 4) % 12], edge_angles[(i + 8) % 12]};
            dscl = '{32'sh0001_0000, 32'sh7fffffff, -32'sh80000000};
            send_transform(dpos, dang, dscl);
        end
        for (int i = 0; i < 8; i++) begin
            dpos = '{-32'sh1, 32'sh0, 32'sh12345678};
            dang = '{edge_angles[i], edge_angles[i + 1], edge_angles[i + 4]};
            if (i % 2) begin
                dscl = '{-32'sh80000000, -32'sh80000000, -32'sh80000000};
            end else begin
                dscl = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
            end
            send_transform(dpos, dang, dscl);
        end

        send_random(80);
        // Hold the sender off until the pipeline has emptied completely.
        wait_drained();
        sender_idle = 52;
        receiver_idle = 27;
        send_random(90);
        sender_idle = 0;
        receiver_idle = 0;
        send_random(90);

        wait_drained();
        repeat (PIPE_LATENCY) @(posedge aclk);
        if (board.error_count == 0 && board.pending_elems.size() == 0) begin
            $display("trs_model_matrix_builder_top_tb OK");
        end else begin
            $display("trs_model_matrix_builder_top_tb NOT OK");
        end
        $finish;
    end
endmodule
